@@ hdl/bsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsc_pkg
// shared constants, types and the port lookup for the banner classifier
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int VersionLimitDefault = 64;
    localparam int RawDepth  = 10;
    localparam int TrimDepth = 5;
    localparam int WinDepth  = 13;
    localparam logic [6:0] PosMax = 7'd127;

    localparam logic [5:0] SVC_EMPTY   = 6'd0;
    localparam logic [5:0] SVC_SSH     = 6'd1;
    localparam logic [5:0] SVC_SMTP    = 6'd2;
    localparam logic [5:0] SVC_FTP     = 6'd3;
    localparam logic [5:0] SVC_HTTP    = 6'd4;
    localparam logic [5:0] SVC_IMAP    = 6'd5;
    localparam logic [5:0] SVC_POP3    = 6'd6;
    localparam logic [5:0] SVC_VNC     = 6'd7;
    localparam logic [5:0] SVC_TLS     = 6'd8;
    localparam logic [5:0] SVC_GREET   = 6'd9;
    localparam logic [5:0] SVC_FRAMED  = 6'd10;
    localparam logic [5:0] SVC_RESP    = 6'd11;
    localparam logic [5:0] SVC_UNKNOWN = 6'd53;

    // match flags handed from the tracker to the decision stage
    typedef struct packed {
        logic       ssh;
        logic       t220;
        logic       smtp;
        logic       ftp;
        logic       http;
        logic       imap;
        logic       pop3;
        logic       vnc;
        logic       tls;
        logic       greet;
        logic       framed;
        logic       resp;
        logic       no_bytes;
    } match_t;

    function automatic logic [5:0] port_code(input logic [15:0] p);
        logic [5:0] c;
        begin
            unique case (p)
                16'd21: c = 6'd3;
                16'd22: c = 6'd1;
                16'd23: c = 6'd12;
                16'd25, 16'd587, 16'd465: c = 6'd2;
                16'd53: c = 6'd13;
                16'd80, 16'd3000, 16'd5000, 16'd8080, 16'd8000, 16'd8081,
                16'd9090, 16'd8888: c = 6'd4;
                16'd110: c = 6'd6;
                16'd111: c = 6'd14;
                16'd135: c = 6'd15;
                16'd139, 16'd445: c = 6'd16;
                16'd143: c = 6'd5;
                16'd161: c = 6'd17;
                16'd389: c = 6'd18;
                16'd443, 16'd8443: c = 6'd19;
                16'd636: c = 6'd20;
                16'd993: c = 6'd21;
                16'd995: c = 6'd22;
                16'd1433: c = 6'd23;
                16'd1521: c = 6'd24;
                16'd1723: c = 6'd25;
                16'd1883: c = 6'd26;
                16'd2049: c = 6'd27;
                16'd2181: c = 6'd28;
                16'd2375: c = 6'd29;
                16'd2376: c = 6'd30;
                16'd2379: c = 6'd31;
                16'd2380: c = 6'd32;
                16'd3306: c = 6'd9;
                16'd3389: c = 6'd33;
                16'd5432: c = 6'd10;
                16'd5672: c = 6'd34;
                16'd5900: c = 6'd7;
                16'd5984: c = 6'd35;
                16'd5985: c = 6'd36;
                16'd6379: c = 6'd11;
                16'd6443: c = 6'd37;
                16'd7474: c = 6'd38;
                16'd8086: c = 6'd39;
                16'd8500: c = 6'd40;
                16'd9000: c = 6'd41;
                16'd9042: c = 6'd42;
                16'd9092: c = 6'd43;
                16'd9200: c = 6'd44;
                16'd9300: c = 6'd45;
                16'd11211: c = 6'd46;
                16'd15672: c = 6'd47;
                16'd27017: c = 6'd48;
                16'd27018: c = 6'd49;
                16'd27019: c = 6'd50;
                16'd28015: c = 6'd51;
                16'd50051: c = 6'd52;
                default: c = 6'd0;
            endcase
            return c;
        end
    endfunction

endpackage

@@ hdl/bsc_tracker.sv @@
// ----------------------------------------------------------------------------
// bsc_tracker
// per-byte banner state: heads, window, substring and greeting trackers
// ----------------------------------------------------------------------------
module bsc_tracker #(
    parameter int VERSION_LIMIT = bsc_pkg::VersionLimitDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          data_byte,
    input  logic                has_byte,
    input  logic                end_of_banner,
    output bsc_pkg::match_t     match
);

    logic [7:0] raw_reg  [bsc_pkg::RawDepth];
    logic [7:0] raw_next [bsc_pkg::RawDepth];
    logic [7:0] trim_reg [bsc_pkg::TrimDepth];
    logic [7:0] trim_next[bsc_pkg::TrimDepth];
    logic [7:0] win_reg  [bsc_pkg::WinDepth];
    logic [7:0] win_next [bsc_pkg::WinDepth];
    logic [6:0] rpos_reg, rpos_next;
    logic [2:0] tpos_reg, tpos_next;
    logic       lead_reg, lead_next;
    logic [3:0] seen_reg, seen_next;
    logic [3:0] greet_reg, greet_next;
    logic [7:0] c;
    logic [7:0] buf14[14];
    logic       ws;

    function automatic logic is_dig(input logic [7:0] x);
        return x >= 8'h30 && x <= 8'h39;
    endfunction

    function automatic logic is_ver(input logic [7:0] x);
        return is_dig(x) || (x >= 8'h61 && x <= 8'h7a) || (x >= 8'h41 && x <= 8'h5a)
            || x == 8'h2e || x == 8'h2d || x == 8'h5f || x == 8'h2b || x == 8'h20;
    endfunction

    // one greeting offset; g = {hit, alive}
    function automatic logic [1:0] greet_step(input logic [1:0] g, input logic [6:0] p,
                                              input logic [6:0] off, input logic [7:0] x);
        logic [1:0] r;
        logic [6:0] k;
        logic       ok;
        begin
            r  = g;
            k  = p - off;
            ok = 1'b1;
            if (g[0] && !g[1] && p >= off) begin
                if (k == 7'd0)
                    ok = (x == 8'h0a || x == 8'h09);
                else if (k == 7'd1)
                    ok = is_dig(x);
                else if (k > 7'(VERSION_LIMIT))
                    ok = 1'b0;
                else if (x == 8'h00)
                    r[1] = 1'b1;
                else
                    ok = is_ver(x);
                if (!ok)
                    r[0] = 1'b0;
            end
            return r;
        end
    endfunction

    function automatic logic tail(input logic [7:0] b[14], input logic [111:0] pat,
                                  input int n);
        logic m;
        begin
            m = 1'b1;
            for (int i = 0; i < 14; i++)
                if (i < n && b[13 - i] != pat[8*i +: 8])
                    m = 1'b0;
            return m;
        end
    endfunction

    assign c = data_byte;
    assign ws = c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;

    always_comb
    begin
        logic [1:0] g0, g4;
        g0         = greet_reg[1:0];
        g4         = greet_reg[3:2];
        raw_next   = raw_reg;
        trim_next  = trim_reg;
        win_next   = win_reg;
        rpos_next  = rpos_reg;
        tpos_next  = tpos_reg;
        lead_next  = lead_reg;
        seen_next  = seen_reg;
        greet_next = greet_reg;
        for (int i = 0; i < 13; i++)
            buf14[i] = win_reg[i];
        buf14[13] = c;
        if (has_byte) begin
            for (int i = 0; i < bsc_pkg::RawDepth; i++)
                if (rpos_reg == 7'(i))
                    raw_next[i] = c;
            if (rpos_reg == 7'd3 && c != 8'h00)
                greet_next[2] = 1'b0;
            g0 = greet_step({greet_reg[1], greet_reg[0]}, rpos_reg, 7'd0, c);
            g4 = greet_step({greet_reg[3], greet_next[2]}, rpos_reg, 7'd4, c);
            greet_next = {g4[1], g4[0], g0[1], g0[0]};
            if (rpos_reg != bsc_pkg::PosMax)
                rpos_next = rpos_reg + 7'd1;
            if (!(lead_reg && ws)) begin
                lead_next = 1'b0;
                for (int i = 0; i < bsc_pkg::TrimDepth; i++)
                    if (tpos_reg == 3'(i))
                        trim_next[i] = c;
                if (tpos_reg != 3'd5)
                    tpos_next = tpos_reg + 3'd1;
            end
            if (tail(buf14, 112'h534d5450, 4)) seen_next[0] = 1'b1;
            if (tail(buf14, 112'h465450, 3)) seen_next[1] = 1'b1;
            if (tail(buf14, 112'h485454502f312e, 7)) seen_next[2] = 1'b1;
            if (tail(buf14, 112'h72656469735f76657273696f6e3a, 14)) seen_next[3] = 1'b1;
            for (int i = 0; i < 13; i++)
                win_next[i] = buf14[i + 1];
        end
    end

    // decision inputs are taken from the updated state
    always_comb
    begin
        logic [31:0] len;
        logic e4, e5;
        match.ssh  = tpos_next >= 3'd4 && trim_next[0] == 8'h53 && trim_next[1] == 8'h53
            && trim_next[2] == 8'h48 && trim_next[3] == 8'h2d;
        match.t220 = tpos_next >= 3'd4 && trim_next[0] == 8'h32 && trim_next[1] == 8'h32
            && trim_next[2] == 8'h30 && (trim_next[3] == 8'h20 || trim_next[3] == 8'h2d);
        match.smtp = seen_next[0];
        match.ftp  = seen_next[1];
        match.http = (tpos_next == 3'd5 && trim_next[0] == 8'h48 && trim_next[1] == 8'h54
            && trim_next[2] == 8'h54 && trim_next[3] == 8'h50 && trim_next[4] == 8'h2f)
            || seen_next[2];
        match.imap = tpos_next >= 3'd4 && trim_next[0] == 8'h2a && trim_next[1] == 8'h20
            && trim_next[2] == 8'h4f && trim_next[3] == 8'h4b;
        match.pop3 = tpos_next >= 3'd3 && trim_next[0] == 8'h2b && trim_next[1] == 8'h4f
            && trim_next[2] == 8'h4b;
        match.vnc  = tpos_next >= 3'd3 && trim_next[0] == 8'h52 && trim_next[1] == 8'h46
            && trim_next[2] == 8'h42;
        e5 = rpos_next >= 7'd5;
        match.tls   = e5 && raw_next[0] == 8'h16 && raw_next[1] == 8'h03;
        match.greet = greet_next[1] || greet_next[3];
        len = {raw_next[1], raw_next[2], raw_next[3], raw_next[4]};
        match.framed = e5 && (raw_next[0] == 8'h45 || raw_next[0] == 8'h52)
            && len >= 32'd4 && len <= 32'h10000;
        e4 = rpos_next >= 7'd4;
        match.resp = (e5 && raw_next[0] == 8'h2b && raw_next[1] == 8'h50
                && raw_next[2] == 8'h4f && raw_next[3] == 8'h4e && raw_next[4] == 8'h47)
            || (e4 && raw_next[0] == 8'h2d && raw_next[1] == 8'h45
                && raw_next[2] == 8'h52 && raw_next[3] == 8'h52)
            || (rpos_next >= 7'd7 && raw_next[0] == 8'h2d && raw_next[1] == 8'h4e
                && raw_next[2] == 8'h4f && raw_next[3] == 8'h41 && raw_next[4] == 8'h55
                && raw_next[5] == 8'h54 && raw_next[6] == 8'h48)
            || (rpos_next >= 7'd7 && raw_next[0] == 8'h2d && raw_next[1] == 8'h44
                && raw_next[2] == 8'h45 && raw_next[3] == 8'h4e && raw_next[4] == 8'h49
                && raw_next[5] == 8'h45 && raw_next[6] == 8'h44)
            || (rpos_next >= 7'd10 && raw_next[0] == 8'h2d && raw_next[1] == 8'h57
                && raw_next[2] == 8'h52 && raw_next[3] == 8'h4f && raw_next[4] == 8'h4e
                && raw_next[5] == 8'h47 && raw_next[6] == 8'h50 && raw_next[7] == 8'h41
                && raw_next[8] == 8'h53 && raw_next[9] == 8'h53)
            || seen_next[3]
            || (rpos_next >= 7'd2 && raw_next[0] == 8'h24
                && (is_dig(raw_next[1]) || raw_next[1] == 8'h2d));
        match.no_bytes = rpos_next == 7'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rpos_reg  <= '0;
            tpos_reg  <= '0;
            lead_reg  <= 1'b1;
            seen_reg  <= '0;
            greet_reg <= 4'b0101;
            for (int i = 0; i < bsc_pkg::RawDepth; i++) raw_reg[i] <= '0;
            for (int i = 0; i < bsc_pkg::TrimDepth; i++) trim_reg[i] <= '0;
            for (int i = 0; i < bsc_pkg::WinDepth; i++) win_reg[i] <= '0;
        end else if (take) begin
            if (end_of_banner) begin
                rpos_reg  <= '0;
                tpos_reg  <= '0;
                lead_reg  <= 1'b1;
                seen_reg  <= '0;
                greet_reg <= 4'b0101;
                for (int i = 0; i < bsc_pkg::RawDepth; i++) raw_reg[i] <= '0;
                for (int i = 0; i < bsc_pkg::TrimDepth; i++) trim_reg[i] <= '0;
                for (int i = 0; i < bsc_pkg::WinDepth; i++) win_reg[i] <= '0;
            end else begin
                rpos_reg  <= rpos_next;
                tpos_reg  <= tpos_next;
                lead_reg  <= lead_next;
                seen_reg  <= seen_next;
                greet_reg <= greet_next;
                raw_reg   <= raw_next;
                trim_reg  <= trim_next;
                win_reg   <= win_next;
            end
        end
    end

endmodule

@@ hdl/bsc_decide.sv @@
// ----------------------------------------------------------------------------
// bsc_decide
// priority decision from match flags and port table
// ----------------------------------------------------------------------------
module bsc_decide (
    input  bsc_pkg::match_t match,
    input  logic [15:0]     port,
    output logic [5:0]      service
);

    logic [5:0] pc;

    assign pc = bsc_pkg::port_code(port);

    always_comb
    begin
        priority if (match.ssh)                              service = bsc_pkg::SVC_SSH;
        else if (match.t220 && match.smtp)                   service = bsc_pkg::SVC_SMTP;
        else if (match.t220 && match.ftp)                    service = bsc_pkg::SVC_FTP;
        else if (match.http)                                 service = bsc_pkg::SVC_HTTP;
        else if (match.imap)                                 service = bsc_pkg::SVC_IMAP;
        else if (match.pop3)                                 service = bsc_pkg::SVC_POP3;
        else if (match.vnc)                                  service = bsc_pkg::SVC_VNC;
        else if (match.tls)                                  service = bsc_pkg::SVC_TLS;
        else if (match.greet)                                service = bsc_pkg::SVC_GREET;
        else if (match.framed)                               service = bsc_pkg::SVC_FRAMED;
        else if (match.resp)                                 service = bsc_pkg::SVC_RESP;
        else if (pc != bsc_pkg::SVC_EMPTY)                   service = pc;
        else if (match.no_bytes)                             service = bsc_pkg::SVC_EMPTY;
        else                                                 service = bsc_pkg::SVC_UNKNOWN;
    end

endmodule

@@ hdl/banner_service_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// banner_service_classifier_unit
// classifies a grabbed banner, one byte per request, into a service code
// ----------------------------------------------------------------------------
// latency: the result is valid the cycle after the final request is accepted
// throughput: one request per cycle unless a held result stalls the input; the result register frees as it is taken
// reset: rst_n clears all banner state and drops out_valid
module banner_service_classifier_unit #(
    parameter int VERSION_LIMIT = bsc_pkg::VersionLimitDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] port,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_banner,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  service
);

    bsc_pkg::match_t match;
    logic            take;
    logic [5:0]      svc_next;
    logic            vld_reg;
    logic [5:0]      svc_reg;

    // a request may enter unless a pending result is held by the sink
    assign in_stall = vld_reg && out_stall;
    assign take     = in_valid && !in_stall;

    bsc_tracker #(.VERSION_LIMIT(VERSION_LIMIT)) u_track (
        .clk(clk), .rst_n(rst_n), .take(take), .data_byte(data_byte),
        .has_byte(has_byte), .end_of_banner(end_of_banner), .match(match)
    );

    bsc_decide u_decide (.match(match), .port(port), .service(svc_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end else if (!vld_reg || !out_stall) begin
            vld_reg <= take && end_of_banner;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            svc_reg <= bsc_pkg::SVC_EMPTY;
        end else if (take && end_of_banner) begin
            svc_reg <= svc_next;
        end
    end

    assign out_valid = vld_reg;
    assign service   = svc_reg;

endmodule

@@ hdl/bsc_checker.sv @@
// ----------------------------------------------------------------------------
// bsc_checker
// port-level checks for the banner classifier
// ----------------------------------------------------------------------------
module bsc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       end_of_banner,
    input logic       out_valid,
    input logic       out_stall,
    input logic [5:0] service
);

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> service <= 6'd53)
        else $error("service code out of range");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && end_of_banner) |=> out_valid)
        else $error("final request gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || !out_stall) && !(in_valid && !in_stall && end_of_banner)
            |=> !out_valid)
        else $error("result without final request");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(service))
        else $error("stalled result changed");

endmodule

bind banner_service_classifier_unit bsc_checker u_bsc_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .end_of_banner(end_of_banner), .out_valid(out_valid), .out_stall(out_stall),
    .service(service)
);
